[rtl/core/csp_pkg.sv]
`default_nettype none
package csp_pkg;

  // name table sizing
  localparam int NAME_COUNT   = 17;
  localparam int MAX_NAME_LEN = 11;
  localparam int TABLE_SLOTS  = 32;
  localparam int TEXT_LEN     = 16;

  localparam logic [7:0] HASH_CHAR = 8'h23;

  typedef logic [TEXT_LEN*8-1:0] name_text_t;

  // name text, right aligned: last character in the low byte
  localparam name_text_t NAME_TXT [TABLE_SLOTS] = '{
    0: "aqua",    1: "black",  2: "blue",   3: "fuchsia",
    4: "gray",    5: "green",  6: "lime",   7: "maroon",
    8: "navy",    9: "olive", 10: "purple", 11: "red",
    12: "silver", 13: "teal", 14: "white",  15: "yellow",
    16: "transparent",
    default: '0
  };

  // name length, zero marks an empty slot
  localparam logic [3:0] NAME_LEN [TABLE_SLOTS] = '{
    0: 4'd4,  1: 4'd5,  2: 4'd4,  3: 4'd7,  4: 4'd4,  5: 4'd5,
    6: 4'd4,  7: 4'd6,  8: 4'd4,  9: 4'd5, 10: 4'd6, 11: 4'd3,
    12: 4'd6, 13: 4'd4, 14: 4'd5, 15: 4'd6, 16: 4'd11,
    default: 4'd0
  };

  // fixed color as {red, green, blue}
  localparam logic [23:0] NAME_RGB [TABLE_SLOTS] = '{
    0: 24'h00FFFF,  1: 24'h000000,  2: 24'h0000FF,  3: 24'hFF00FF,
    4: 24'h808080,  5: 24'h008000,  6: 24'h00FF00,  7: 24'h800000,
    8: 24'h000080,  9: 24'h808000, 10: 24'h800080, 11: 24'hFF0000,
    12: 24'hC0C0C0, 13: 24'h008080, 14: 24'hFFFFFF, 15: 24'hFFFF00,
    16: 24'h000000,
    default: 24'h000000
  };

  localparam logic NAME_TRANSP [TABLE_SLOTS] = '{
    16: 1'b1,
    default: 1'b0
  };

  // outcome of the name match for the current character
  typedef struct packed {
    logic       found;
    logic       transp;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } name_hit_t;

  // hex digit decode: {ok, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/csp_in_if.sv]
`default_nettype none
interface csp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

[rtl/core/csp_out_if.sv]
`default_nettype none
interface csp_out_if;
  logic       valid;
  logic       ready;
  logic       is_valid;
  logic       is_transparent;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output is_valid, output is_transparent,
                  output red, output green, output blue, input ready);
  modport sink (input valid, input is_valid, input is_transparent,
                input red, input green, input blue, output ready);
endinterface
`default_nettype wire

[rtl/core/csp_name_match.sv]
`default_nettype none
module csp_name_match
  import csp_pkg::*;
(
  input  wire logic [3:0]            pos,
  input  wire logic [7:0]            lc_char,
  input  wire logic                  last,
  input  wire logic [NAME_COUNT-1:0] cand,
  output logic      [NAME_COUNT-1:0] cand_nxt,
  output name_hit_t                  hit
);

  logic [NAME_COUNT-1:0] full_hit;

  // per name: compare the character at this position
  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      logic [3:0] sh;
      logic [7:0] ch;
      logic       ok;
      sh = 4'(NAME_LEN[i] - 4'd1 - pos);
      ch = NAME_TXT[i][{sh, 3'b000} +: 8];
      ok = cand[i] && (pos < NAME_LEN[i]) && ({1'b0, pos} < 5'(MAX_NAME_LEN))
           && (ch == lc_char);
      cand_nxt[i] = ok;
      full_hit[i] = ok && last && ({1'b0, pos} + 5'd1 == {1'b0, NAME_LEN[i]});
    end
  end

  // at most one name can end here, so an or of the hits selects it
  always_comb begin
    logic [23:0] rgb;
    logic        tr;
    rgb = 24'h0;
    tr  = 1'b0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (full_hit[i]) begin
        rgb = rgb | NAME_RGB[i];
        tr  = tr | NAME_TRANSP[i];
      end
    end
    hit.found  = |full_hit;
    hit.transp = tr;
    hit.red    = rgb[23:16];
    hit.green  = rgb[15:8];
    hit.blue   = rgb[7:0];
  end

endmodule
`default_nettype wire

[rtl/core/color_spec_parser.sv]
`default_nettype none
// color_spec_parser: parses a color text given one character per beat on
// in_ch (char_code, last_char). On the beat with last_char set it gives one
// beat on out_ch: is_valid, is_transparent and red/green/blue. Texts are
// matched case-insensitively against the 17 color names, else as #RGB or
// #RRGGBB. Invalid texts give is_valid 0, is_transparent 1 and zero color.
// Each accepted beat lands in an input register; from there it updates the
// name candidate mask, the character count and the digit store, and a final
// character loads the result register, which drives out_ch.valid. A new
// character can be taken every cycle unless a final character waits behind
// a held result.
// When the receiver stalls, the result is held; non-final characters keep
// flowing through the input register, and the next final character waits
// there with in_ch.ready low until the held result is taken. After each
// result the parse state returns to its start value. Reset (rst_n low,
// synchronous) empties both registers and restores the parse state.
module color_spec_parser
  import csp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  csp_in_if.sink     in_ch,
  csp_out_if.source  out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       in_ready;

  // parse state
  logic [NAME_COUNT-1:0] cand_r, cand_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic                  hex_ok_r, hex_ok_nxt;
  logic [3:0]            hex_dig_r [6];

  // result register
  logic       out_valid_r;
  logic       res_valid_r, res_transp_r;
  logic [7:0] res_red_r, res_green_r, res_blue_r;
  logic       res_valid_nxt, res_transp_nxt;
  logic [7:0] res_red_nxt, res_green_nxt, res_blue_nxt;

  logic [7:0] lc_char;
  logic [4:0] hex_dec;
  logic       dig_wr;
  logic [2:0] dig_idx;
  logic [3:0] dig_eff [6];
  name_hit_t  hit;

  // handshake: a non-final character never waits on the output side
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.last_char;
    end
  end

  // case fold of ascii letters
  assign lc_char = (s1_char_r >= 8'h41 && s1_char_r <= 8'h5A) ?
                   8'(s1_char_r + 8'd32) : s1_char_r;

  csp_name_match u_name (
    .pos      (cnt_r),
    .lc_char  (lc_char),
    .last     (s1_last_r),
    .cand     (cand_r),
    .cand_nxt (cand_nxt),
    .hit      (hit)
  );

  // hex form tracking
  assign hex_dec = hex_decode(s1_char_r);
  assign dig_wr  = (cnt_r >= 4'd1) && (cnt_r <= 4'd6) && hex_dec[4];
  assign dig_idx = 3'(cnt_r - 4'd1);

  always_comb begin
    if (cnt_r == 4'd0) begin
      hex_ok_nxt = hex_ok_r && (s1_char_r == HASH_CHAR);
    end else if (cnt_r <= 4'd6) begin
      hex_ok_nxt = hex_ok_r && hex_dec[4];
    end else begin
      hex_ok_nxt = 1'b0;
    end
    cnt_nxt = (cnt_r == 4'hF) ? cnt_r : 4'(cnt_r + 4'd1);
  end

  // digits including the one written by this character
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dig_eff[k] = (dig_wr && dig_idx == 3'(k)) ? hex_dec[3:0] : hex_dig_r[k];
    end
  end

  // result selection
  always_comb begin
    res_valid_nxt  = 1'b0;
    res_transp_nxt = 1'b1;
    res_red_nxt    = 8'h00;
    res_green_nxt  = 8'h00;
    res_blue_nxt   = 8'h00;
    if (hit.found) begin
      res_valid_nxt  = 1'b1;
      res_transp_nxt = hit.transp;
      res_red_nxt    = hit.red;
      res_green_nxt  = hit.green;
      res_blue_nxt   = hit.blue;
    end else if (hex_ok_nxt && cnt_r == 4'd3) begin
      res_valid_nxt  = 1'b1;
      res_transp_nxt = 1'b0;
      res_red_nxt    = {dig_eff[0], dig_eff[0]};
      res_green_nxt  = {dig_eff[1], dig_eff[1]};
      res_blue_nxt   = {dig_eff[2], dig_eff[2]};
    end else if (hex_ok_nxt && cnt_r == 4'd6) begin
      res_valid_nxt  = 1'b1;
      res_transp_nxt = 1'b0;
      res_red_nxt    = {dig_eff[0], dig_eff[1]};
      res_green_nxt  = {dig_eff[2], dig_eff[3]};
      res_blue_nxt   = {dig_eff[4], dig_eff[5]};
    end
  end

  // parse state update, restart after a final character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r   <= '1;
      cnt_r    <= 4'd0;
      hex_ok_r <= 1'b1;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        cand_r   <= '1;
        cnt_r    <= 4'd0;
        hex_ok_r <= 1'b1;
      end else begin
        cand_r   <= cand_nxt;
        cnt_r    <= cnt_nxt;
        hex_ok_r <= hex_ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && dig_wr) begin
      hex_dig_r[dig_idx] <= hex_dec[3:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      res_valid_r  <= res_valid_nxt;
      res_transp_r <= res_transp_nxt;
      res_red_r    <= res_red_nxt;
      res_green_r  <= res_green_nxt;
      res_blue_r   <= res_blue_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_valid       = res_valid_r;
  assign out_ch.is_transparent = res_transp_r;
  assign out_ch.red            = res_red_r;
  assign out_ch.green          = res_green_r;
  assign out_ch.blue           = res_blue_r;

`ifndef SYNTH
  // an invalid result carries the transparent flag and zero color
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_valid_r) |->
      (res_transp_r && res_red_r == 8'h00 && res_green_r == 8'h00 &&
       res_blue_r == 8'h00))
    else $error("invalid result with color");

  // a final character restarts the parse state
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (cand_r == '1 && cnt_r == 4'd0 && hex_ok_r))
    else $error("parse state not restarted");

  // input stalls only behind a held result and a waiting final character
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");
`endif

endmodule
`default_nettype wire
